// ===== rtl/ffca_pkg.sv =====
`default_nettype none

package ffca_pkg;

	localparam int DATA_W = 16;
	localparam int BIU_W = 6;
	localparam int FUNC_W = 2;
	localparam int STAT_W = 2;
	localparam int CFG_IDX_W = 2;

	localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_FREE = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_INIT = 2'd2;

	localparam logic [STAT_W-1:0] ST_OK = 2'd0;
	localparam logic [STAT_W-1:0] ST_NOFIT = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_POOL_SIZE = 2'd1;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [DATA_W-1:0] amount;
		logic [DATA_W-1:0] range_start;
	} req_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [DATA_W-1:0] grant_base;
		logic [BIU_W-1:0]  blocks_in_use;
	} rsp_t;

	typedef struct packed {
		logic [DATA_W-1:0] start;
		logic [DATA_W-1:0] len;
	} entry_t;

endpackage

`default_nettype wire

// ===== rtl/ffca_mem.sv =====
`default_nettype none

module ffca_mem #(
	parameter int DEPTH = 32,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic            clk,
	input  wire logic            we,
	input  wire logic [AW-1:0]   waddr,
	input  wire ffca_pkg::entry_t wdata,
	input  wire logic [AW-1:0]   raddr,
	output ffca_pkg::entry_t     rdata
);
	import ffca_pkg::*;

	entry_t mem_q [DEPTH];
	entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/ffca_alu.sv =====
`default_nettype none

module ffca_alu (
	input  wire logic [ffca_pkg::DATA_W-1:0] a,
	input  wire logic [ffca_pkg::DATA_W-1:0] b,
	input  wire logic                        sub,
	output logic [ffca_pkg::DATA_W:0]        res
);
	import ffca_pkg::*;

	// bit DATA_W is carry on add, borrow (a < b) on subtract
	always_comb begin
		if (sub) begin
			res = {1'b0, a} - {1'b0, b};
		end else begin
			res = {1'b0, a} + {1'b0, b};
		end
	end

endmodule

`default_nettype wire

// ===== rtl/first_fit_coalescing_allocator_unit.sv =====
`default_nettype none

// channel  | handshake             | payload
// ---------+-----------------------+---------------------------------------
// request  | req_valid / req_ready | req: func, amount, range_start
// response | rsp_valid / rsp_ready | rsp: status, grant_base, blocks_in_use
// config   | cfg_valid / cfg_ready | cfg_index, cfg_data (always ready)
//
// one request at a time; a shared 17-bit add/subtract unit and one list memory port set
// the pace. allocate scans for the first block that fits and updates it, then moves the
// blocks behind the hit down when the hit block empties; free scans for the insert point,
// checks for merges, then moves the blocks behind the insert point up on insert, or the
// blocks behind the absorbed block down on a two-sided merge; init and ignored respond directly.
// reset empties the list and clears the config registers; no clearing pass.
// a pending response does not block the next request until its own response is due.

module first_fit_coalescing_allocator_unit #(
	parameter int MAX_BLOCKS = 32
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           req_valid,
	output logic                                req_ready,
	input  wire ffca_pkg::req_t                 req,
	output logic                                rsp_valid,
	input  wire logic                           rsp_ready,
	output ffca_pkg::rsp_t                      rsp,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [ffca_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [ffca_pkg::DATA_W-1:0]    cfg_data
);
	import ffca_pkg::*;

	localparam int AW = $clog2(MAX_BLOCKS);
	localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_SCAN_A = 4'd1;
	localparam logic [3:0] S_A_UPD  = 4'd2;
	localparam logic [3:0] S_RM_PRE = 4'd3;
	localparam logic [3:0] S_RM_MV  = 4'd4;
	localparam logic [3:0] S_SCAN_F = 4'd5;
	localparam logic [3:0] S_F_N1   = 4'd6;
	localparam logic [3:0] S_F_N2   = 4'd7;
	localparam logic [3:0] S_F_P1   = 4'd8;
	localparam logic [3:0] S_F_P2   = 4'd9;
	localparam logic [3:0] S_F_P3   = 4'd10;
	localparam logic [3:0] S_F_ACT  = 4'd11;
	localparam logic [3:0] S_SU_PRE = 4'd12;
	localparam logic [3:0] S_SU_MV  = 4'd13;
	localparam logic [3:0] S_SU_FIN = 4'd14;
	localparam logic [3:0] S_DONE   = 4'd15;

	logic [3:0] state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d, idx_q, idx_d, at_q, at_d;
	logic ovalid_q, ovalid_d;
	logic [DATA_W-1:0] base_q, size_q;

	logic [DATA_W-1:0] amt_q, rs_q;
	entry_t cur_q, cur_d, prv_q, prv_d;
	logic eq_q, eq_d, nxt_q, nxt_d, pok_q, pok_d;
	logic [DATA_W-1:0] nlen_q, nlen_d, plen_q, plen_d, grant_q, grant_d;
	logic [STAT_W-1:0] st_q, st_d;
	rsp_t rsp_q, rsp_d;

	logic mem_we;
	logic [AW-1:0] mem_waddr, mem_raddr;
	entry_t mem_wdata, mem_rdata;

	logic [DATA_W-1:0] alu_a, alu_b;
	logic alu_sub;
	logic [DATA_W:0] alu_res;

	logic [CNT_W:0] idx_p1, idx_p2, cnt_x;
	logic [CNT_W-1:0] idx_m1, idx_m2, at_m1;
	logic req_acc;

	ffca_mem #(.DEPTH(MAX_BLOCKS)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	ffca_alu u_alu (
		.a   (alu_a),
		.b   (alu_b),
		.sub (alu_sub),
		.res (alu_res)
	);

	assign req_ready = (state_q == S_IDLE);
	assign req_acc = req_valid && req_ready;
	assign cfg_ready = 1'b1;
	assign rsp_valid = ovalid_q;
	assign rsp = rsp_q;

	assign idx_p1 = {1'b0, idx_q} + (CNT_W+1)'(1);
	assign idx_p2 = {1'b0, idx_q} + (CNT_W+1)'(2);
	assign cnt_x = {1'b0, cnt_q};
	assign idx_m1 = idx_q - CNT_W'(1);
	assign idx_m2 = idx_q - CNT_W'(2);
	assign at_m1 = at_q - CNT_W'(1);

	always_comb begin
		state_d = state_q;
		cnt_d = cnt_q;
		idx_d = idx_q;
		at_d = at_q;
		cur_d = cur_q;
		prv_d = prv_q;
		eq_d = eq_q;
		nxt_d = nxt_q;
		pok_d = pok_q;
		nlen_d = nlen_q;
		plen_d = plen_q;
		grant_d = grant_q;
		st_d = st_q;
		rsp_d = rsp_q;
		ovalid_d = ovalid_q && !rsp_ready;
		mem_we = 1'b0;
		mem_waddr = idx_q[AW-1:0];
		mem_wdata = mem_rdata;
		mem_raddr = '0;
		alu_a = '0;
		alu_b = '0;
		alu_sub = 1'b0;

		unique case (state_q)
			S_IDLE: begin
				if (req_acc) begin
					idx_d = '0;
					st_d = ST_OK;
					grant_d = '0;
					unique case (req.func)
						FUNC_ALLOC: state_d = S_SCAN_A;
						FUNC_FREE: begin
							if (req.amount == '0) begin
								state_d = S_DONE;
							end else begin
								state_d = S_SCAN_F;
							end
						end
						FUNC_INIT: begin
							mem_we = 1'b1;
							mem_waddr = '0;
							mem_wdata = '{start: base_q, len: size_q};
							cnt_d = (size_q != '0) ? CNT_W'(1) : '0;
							state_d = S_DONE;
						end
						default: state_d = S_DONE;
					endcase
				end
			end
			S_SCAN_A: begin
				mem_raddr = idx_p1[AW-1:0];
				alu_a = mem_rdata.len;
				alu_b = amt_q;
				alu_sub = 1'b1;
				if (idx_q == cnt_q) begin
					st_d = ST_NOFIT;
					state_d = S_DONE;
				end else if (!alu_res[DATA_W]) begin
					grant_d = mem_rdata.start;
					cur_d = mem_rdata;
					nlen_d = alu_res[DATA_W-1:0];
					state_d = S_A_UPD;
				end else begin
					idx_d = idx_p1[CNT_W-1:0];
				end
			end
			S_A_UPD: begin
				alu_a = cur_q.start;
				alu_b = amt_q;
				if (nlen_q == '0) begin
					state_d = S_RM_PRE;
				end else begin
					mem_we = 1'b1;
					mem_wdata = '{start: alu_res[DATA_W-1:0], len: nlen_q};
					state_d = S_DONE;
				end
			end
			S_RM_PRE: begin
				mem_raddr = idx_p1[AW-1:0];
				if (idx_p1 >= cnt_x) begin
					cnt_d = cnt_q - CNT_W'(1);
					state_d = S_DONE;
				end else begin
					state_d = S_RM_MV;
				end
			end
			S_RM_MV: begin
				mem_we = 1'b1;
				mem_wdata = mem_rdata;
				mem_raddr = idx_p2[AW-1:0];
				idx_d = idx_p1[CNT_W-1:0];
				if (idx_p2 >= cnt_x) begin
					cnt_d = cnt_q - CNT_W'(1);
					state_d = S_DONE;
				end
			end
			S_SCAN_F: begin
				mem_raddr = idx_p1[AW-1:0];
				alu_a = mem_rdata.start;
				alu_b = rs_q;
				alu_sub = 1'b1;
				if (idx_q == cnt_q) begin
					at_d = idx_q;
					state_d = S_F_N1;
				end else if (alu_res[DATA_W]) begin
					prv_d = mem_rdata;
					idx_d = idx_p1[CNT_W-1:0];
				end else begin
					cur_d = mem_rdata;
					at_d = idx_q;
					state_d = S_F_N1;
				end
			end
			S_F_N1: begin
				alu_a = rs_q;
				alu_b = amt_q;
				eq_d = (alu_res == {1'b0, cur_q.start}) && (at_q != cnt_q);
				state_d = S_F_N2;
			end
			S_F_N2: begin
				alu_a = amt_q;
				alu_b = cur_q.len;
				nxt_d = eq_q && !alu_res[DATA_W];
				nlen_d = alu_res[DATA_W-1:0];
				state_d = S_F_P1;
			end
			S_F_P1: begin
				alu_a = prv_q.start;
				alu_b = prv_q.len;
				eq_d = (alu_res == {1'b0, rs_q}) && (at_q != '0);
				state_d = S_F_P2;
			end
			S_F_P2: begin
				alu_a = prv_q.len;
				alu_b = amt_q;
				pok_d = eq_q && !alu_res[DATA_W];
				plen_d = alu_res[DATA_W-1:0];
				state_d = S_F_P3;
			end
			S_F_P3: begin
				alu_a = plen_q;
				alu_b = nxt_q ? cur_q.len : '0;
				pok_d = pok_q && !alu_res[DATA_W];
				plen_d = alu_res[DATA_W-1:0];
				state_d = S_F_ACT;
			end
			S_F_ACT: begin
				if (nxt_q && pok_q) begin
					mem_we = 1'b1;
					mem_waddr = at_m1[AW-1:0];
					mem_wdata = '{start: prv_q.start, len: plen_q};
					idx_d = at_q;
					state_d = S_RM_PRE;
				end else if (nxt_q) begin
					mem_we = 1'b1;
					mem_waddr = at_q[AW-1:0];
					mem_wdata = '{start: rs_q, len: nlen_q};
					state_d = S_DONE;
				end else if (pok_q) begin
					mem_we = 1'b1;
					mem_waddr = at_m1[AW-1:0];
					mem_wdata = '{start: prv_q.start, len: plen_q};
					state_d = S_DONE;
				end else if (cnt_q == CNT_W'(MAX_BLOCKS)) begin
					st_d = ST_FULL;
					state_d = S_DONE;
				end else begin
					idx_d = cnt_q;
					state_d = S_SU_PRE;
				end
			end
			S_SU_PRE: begin
				mem_raddr = idx_m1[AW-1:0];
				if (idx_q == at_q) begin
					state_d = S_SU_FIN;
				end else begin
					state_d = S_SU_MV;
				end
			end
			S_SU_MV: begin
				mem_we = 1'b1;
				mem_wdata = mem_rdata;
				mem_raddr = idx_m2[AW-1:0];
				idx_d = idx_m1;
				if (idx_m1 == at_q) begin
					state_d = S_SU_FIN;
				end
			end
			S_SU_FIN: begin
				mem_we = 1'b1;
				mem_waddr = at_q[AW-1:0];
				mem_wdata = '{start: rs_q, len: amt_q};
				cnt_d = cnt_q + CNT_W'(1);
				state_d = S_DONE;
			end
			S_DONE: begin
				if (!ovalid_q || rsp_ready) begin
					rsp_d = '{status: st_q, grant_base: grant_q,
						blocks_in_use: BIU_W'(cnt_q)};
					ovalid_d = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			idx_q <= '0;
			at_q <= '0;
			ovalid_q <= 1'b0;
			base_q <= '0;
			size_q <= '0;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
			idx_q <= idx_d;
			at_q <= at_d;
			ovalid_q <= ovalid_d;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_POOL_BASE: base_q <= cfg_data;
					CFG_POOL_SIZE: size_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			amt_q <= req.amount;
			rs_q <= req.range_start;
		end
		cur_q <= cur_d;
		prv_q <= prv_d;
		eq_q <= eq_d;
		nxt_q <= nxt_d;
		pok_q <= pok_d;
		nlen_q <= nlen_d;
		plen_q <= plen_d;
		grant_q <= grant_d;
		st_q <= st_d;
		rsp_q <= rsp_d;
	end

endmodule

`default_nettype wire
